>>> src/ste_pkg.sv
package ste_pkg;

   localparam int COUNT_BITS = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 64;
   localparam int MAX_CHARS = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUOTE_MODE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LETTER_TABLE = 1'b1;

   localparam logic [1:0] QUOTE_SINGLE = 2'd1;
   localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

   localparam logic [63:0] LETTER_TABLE_RESET = 64'h0000_7266_766E_7462;

   localparam logic [6:0] CH_BACKSLASH = 7'h5C;
   localparam logic [6:0] CH_SQUOTE = 7'h27;
   localparam logic [6:0] CH_DQUOTE = 7'h22;
   localparam logic [6:0] CH_X = 7'h78;
   localparam logic [6:0] CH_U = 7'h75;

   typedef struct packed {
      logic [15:0] unit;
      logic        last_unit;
      logic        no_unit;
   } req_word_type;

   typedef struct packed {
      logic [6:0]  out_char;
      logic        run_last;
      logic        string_done;
      logic [31:0] chars_emitted;
   } rsp_word_type;

   // One item's expansion: up to eight characters, its length and whether it
   // closes the string.
   typedef struct packed {
      logic [MAX_CHARS-1:0][6:0] chars;
      logic [3:0]                len;
      logic                      ends;
   } desc_type;

   function automatic logic [6:0] hex_digit(input logic [3:0] v);
      logic [6:0] d;
      if (v < 4'd10) d = 7'h30 + 7'(v);
      else d = 7'h37 + 7'(v);
      return d;
   endfunction

endpackage

>>> src/string_escape_encoder.sv
// Channel | Ports                                 | Word
// input   | req_push, req_full, req_word          | one 16-bit unit plus end flags
// result  | rsp_empty, rsp_pop, rsp_word          | one escaped ASCII character
// config  | csr_we, csr_index, csr_wdata          | quote mode (0), letter table (1)
//
// An item expands to 0 to 8 characters (at most 8: quote, \uHHHH, quote); the
// back end sends one character per cycle unless the output register is held full
// by a stalled rsp_pop.
// A two-entry queue sits between the classifier and the back end; a single
// output register holds the current word.
// Reset is synchronous, active high, clears quote mode, loads the default letter
// table, and clears the open-string flag, count and all valid flags.
// req_full rises only when the queue is full; a stalled rsp_pop holds the back end.
module string_escape_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  ste_pkg::req_word_type               req_word,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output ste_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_we,
   input  logic [ste_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ste_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import ste_pkg::*;

   logic     q_push, q_full, q_pop, q_valid;
   desc_type push_desc, pop_desc;

   // Accept whenever the queue has room.
   assign req_full = q_full;

   // Classify a unit into its full character expansion.
   ste_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_desc    (push_desc)
   );

   // Hold classified items until the back end is free.
   ste_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_desc  (pop_desc)
   );

   // Send characters one at a time and keep the running count.
   ste_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_desc    (pop_desc),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

>>> src/ste_front.sv
module ste_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  ste_pkg::req_word_type               req_word,
   input  logic                                csr_we,
   input  logic [ste_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ste_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                q_full,
   output logic                                q_push,
   output ste_pkg::desc_type                   q_desc
);
   import ste_pkg::*;

   logic [1:0]  quote_mode_ff, quote_mode_in;
   logic [63:0] letters_ff, letters_in;
   logic        opened_ff, opened_in;

   logic [15:0]      u;
   logic [6:0]       q;
   logic             has_q;
   logic             ends;
   logic [7:0]       letter;
   logic             letter_ok;
   logic [7:0][6:0]  esc;
   logic [3:0]       esc_len;
   logic             put_open, put_close;
   logic [3:0]       base, j;

   assign q_push = req_push && !q_full;

   always_comb begin
      u = req_word.unit;
      ends = req_word.last_unit || req_word.no_unit;
      unique case (quote_mode_ff)
         QUOTE_SINGLE: q = CH_SQUOTE;
         QUOTE_DOUBLE: q = CH_DQUOTE;
         default:      q = 7'd0;
      endcase
      has_q = (q != 7'd0);

      letter = letters_ff[8*u[2:0] +: 8];
      letter_ok = (u[15:3] == 13'd1) && (letter >= 8'h20) && (letter < 8'h7F);

      esc = '0;
      esc_len = 4'd0;
      if (req_word.no_unit) begin
         esc_len = 4'd0;
      end else if (u < 16'h20 && letter_ok) begin
         esc[0] = CH_BACKSLASH;
         esc[1] = letter[6:0];
         esc_len = 4'd2;
      end else if (u < 16'h20 || (u >= 16'h7F && u < 16'h100)) begin
         esc[0] = CH_BACKSLASH;
         esc[1] = CH_X;
         esc[2] = hex_digit(u[7:4]);
         esc[3] = hex_digit(u[3:0]);
         esc_len = 4'd4;
      end else if (u < 16'h7F) begin
         if ((has_q && u[6:0] == q) || u[6:0] == CH_BACKSLASH) begin
            esc[0] = CH_BACKSLASH;
            esc[1] = u[6:0];
            esc_len = 4'd2;
         end else begin
            esc[0] = u[6:0];
            esc_len = 4'd1;
         end
      end else begin
         esc[0] = CH_BACKSLASH;
         esc[1] = CH_U;
         esc[2] = hex_digit(u[15:12]);
         esc[3] = hex_digit(u[11:8]);
         esc[4] = hex_digit(u[7:4]);
         esc[5] = hex_digit(u[3:0]);
         esc_len = 4'd6;
      end

      put_open = !opened_ff && has_q;
      put_close = ends && has_q;
      base = {3'd0, put_open};

      // Lay out opening quote, escape body, closing quote.
      for (int i = 0; i < MAX_CHARS; i++) begin
         j = 4'(i) - base;
         if (4'(i) < base) q_desc.chars[i] = q;
         else if (j < esc_len) q_desc.chars[i] = esc[j[2:0]];
         else q_desc.chars[i] = q;
      end
      q_desc.len = base + esc_len + {3'd0, put_close};
      q_desc.ends = ends;
   end

   always_comb begin
      quote_mode_in = quote_mode_ff;
      letters_in = letters_ff;
      opened_in = opened_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_QUOTE_MODE:   quote_mode_in = csr_wdata[1:0];
            CSR_LETTER_TABLE: letters_in = csr_wdata[63:0];
            default: ;
         endcase
      end
      if (q_push) opened_in = !ends;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_mode_ff <= 2'd0;
         letters_ff <= LETTER_TABLE_RESET;
         opened_ff <= 1'b0;
      end else begin
         quote_mode_ff <= quote_mode_in;
         letters_ff <= letters_in;
         opened_ff <= opened_in;
      end
   end

endmodule

>>> src/ste_queue.sv
module ste_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ste_pkg::desc_type  push_desc,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output ste_pkg::desc_type  pop_desc
);
   import ste_pkg::*;

   desc_type   entry_ff [QUEUE_DEPTH];
   logic [0:0] wr_ptr_ff, wr_ptr_in;
   logic [0:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == 2'(QUEUE_DEPTH));
   assign valid = (cnt_ff != 2'd0);
   assign pop_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> src/ste_back.sv
module ste_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  ste_pkg::desc_type     q_desc,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output ste_pkg::rsp_word_type rsp_word
);
   import ste_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS+31:0] VIEW_MAX = (COUNT_BITS+32)'(32'hFFFF_FFFF);

   desc_type             cur_ff;
   logic                 cur_valid_ff, cur_valid_in;
   logic [2:0]           idx_ff, idx_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_inc;
   logic                 out_valid_ff, out_valid_in;
   rsp_word_type         out_word_ff, out_word_in;

   logic slot_free, emit, is_last, finishing;
   logic [COUNT_BITS+31:0] count_ext;

   assign rsp_empty = !out_valid_ff;
   assign rsp_word = out_word_ff;

   always_comb begin
      slot_free = !out_valid_ff || rsp_pop;
      emit = cur_valid_ff && slot_free;
      is_last = ({1'b0, idx_ff} + 4'd1 == cur_ff.len);
      finishing = emit && is_last;
      q_pop = q_valid && (!cur_valid_ff || finishing);

      count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      count_ext = (COUNT_BITS+32)'(count_inc);

      out_word_in.out_char = cur_ff.chars[idx_ff];
      out_word_in.run_last = is_last;
      out_word_in.string_done = is_last && cur_ff.ends;
      out_word_in.chars_emitted = (count_ext > VIEW_MAX) ? 32'hFFFF_FFFF : count_ext[31:0];

      out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

      // advance within the current item, drop it on its last character
      cur_valid_in = cur_valid_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      if (emit) begin
         idx_in = idx_ff + 3'd1;
         count_in = (is_last && cur_ff.ends) ? '0 : count_inc;
      end
      if (finishing) cur_valid_in = 1'b0;
      if (q_pop) begin
         cur_valid_in = (q_desc.len != 4'd0);
         idx_in = 3'd0;
         if (q_desc.len == 4'd0 && q_desc.ends) count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_desc;
      if (emit) out_word_ff <= out_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= 3'd0;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> ({1'b0, idx_ff} < cur_ff.len))
      else $error("character index beyond item length");

   a_done_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.string_done) |-> out_word_ff.run_last)
      else $error("string end not on last character of its item");

   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      (finishing && cur_ff.ends) |=> (count_ff == '0))
      else $error("count not cleared at end of string");

endmodule
